/* rtl/ist_pkg.sv */
`default_nettype none
package ist_pkg;

	// Operation codes carried in the request selector; code 3 acts as a query
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic was_member;
		logic dropped;
	} res_t;

endpackage
`default_nettype wire

/* rtl/ist_ram.sv */
`default_nettype none
module ist_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/ist_seq.sv */
`default_nettype none
module ist_seq #(
	parameter int unsigned CAPACITY = 16,
	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire logic [1:0]                   req_mode,
	input  wire logic [ist_pkg::VALUE_W-1:0]  req_value,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output ist_pkg::res_t                     res,
	output logic      [CW-1:0]                count,
	output logic                              rd_en,
	output logic      [IW-1:0]                rd_addr,
	input  wire logic [ist_pkg::VALUE_W-1:0]  rd_data,
	output logic                              wr_en,
	output logic      [IW-1:0]                wr_addr,
	output logic      [ist_pkg::VALUE_W-1:0]  wr_data
);

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	ist_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q, slot_q;
	logic          found_q, dropped_q;
	logic [1:0]    mode_q;
	logic [ist_pkg::VALUE_W-1:0] value_q;

	logic hit, last_idx, is_ins, is_rem, full;

	// Shared compare unit: one stored entry against the request value per cycle
	assign hit      = (rd_data == value_q);
	assign last_idx = ((CW'(idx_q) + ONE_C) == count_q);
	assign is_ins   = (mode_q == ist_pkg::MODE_INSERT);
	assign is_rem   = (mode_q == ist_pkg::MODE_REMOVE);
	assign full     = (count_q == CAP_C);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ist_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (count_q == '0) begin
						state_d = (req_mode == ist_pkg::MODE_INSERT) ?
							ist_pkg::ST_WRITE : ist_pkg::ST_DONE;
					end else begin
						state_d = ist_pkg::ST_SCAN;
					end
				end
			end
			ist_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = is_rem ? ist_pkg::ST_LAST : ist_pkg::ST_DONE;
				end else if (last_idx) begin
					state_d = (is_ins && !full) ? ist_pkg::ST_WRITE : ist_pkg::ST_DONE;
				end
			end
			ist_pkg::ST_LAST:  state_d = ist_pkg::ST_DONE;
			ist_pkg::ST_WRITE: state_d = ist_pkg::ST_DONE;
			ist_pkg::ST_DONE: begin
				if (res_ready) begin
					state_d = ist_pkg::ST_IDLE;
				end
			end
			default: state_d = ist_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = slot_q;
		wr_data   = rd_data;
		case (state_q)
			ist_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				rd_en     = req_valid;
			end
			ist_pkg::ST_SCAN: begin
				if (hit) begin
					// fetch the last entry to fill the hole left by a removal
					rd_en   = is_rem;
					rd_addr = IW'(count_q - ONE_C);
				end else if (!last_idx) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + IW'(1);
				end
			end
			ist_pkg::ST_LAST: begin
				wr_en = 1'b1;
			end
			ist_pkg::ST_WRITE: begin
				wr_en   = 1'b1;
				wr_addr = IW'(count_q);
				wr_data = value_q;
			end
			ist_pkg::ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res.was_member = found_q;
	assign res.dropped    = dropped_q;
	assign count          = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ist_pkg::ST_IDLE;
			count_q   <= '0;
			found_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ist_pkg::ST_IDLE: begin
					if (req_valid) begin
						found_q   <= 1'b0;
						dropped_q <= 1'b0;
					end
				end
				ist_pkg::ST_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
					end else if (last_idx) begin
						dropped_q <= is_ins && full;
					end
				end
				ist_pkg::ST_LAST:  count_q <= count_q - ONE_C;
				ist_pkg::ST_WRITE: count_q <= count_q + ONE_C;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ist_pkg::ST_IDLE && req_valid) begin
			mode_q  <= req_mode;
			value_q <= req_value;
			idx_q   <= '0;
		end else if (state_q == ist_pkg::ST_SCAN) begin
			if (hit) begin
				slot_q <= idx_q;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.dropped |-> full)
		else $error("dropped insert while store not full");

	a_drop_member: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.dropped && res.was_member))
		else $error("dropped flag on a present value");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == $past(count_q) + ONE_C || count_q == $past(count_q) - ONE_C))
		else $error("entry count moved by more than one");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted in back-to-back cycles");

endmodule
`default_nettype wire

/* rtl/integer_set_table_unit.sv */
// Flow: an accepted request scans the stored entries, then passes a write state when
//   it writes the RAM, and hands its result to the master-side result register.
// Requests: one at a time, a new one only once the last result has left the sequencer.
//   The single RAM read port feeds one stored entry per cycle to the compare.
// Reset: arst_n clears the count, sequencer and output valid; RAM contents stay
//   undefined and are never used above the count.
`default_nettype none
module integer_set_table_unit #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request side
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] value
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
	// result side
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata    // [0] was_member, [5:1] member_count,
	                                         // [6] dropped, [7] zero
);

	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic          res_valid, res_ready;
	ist_pkg::res_t res;
	logic [CW-1:0] count;

	logic                         rd_en, wr_en;
	logic [IW-1:0]                rd_addr, wr_addr;
	logic [ist_pkg::VALUE_W-1:0]  rd_data, wr_data;

	// Result register: out_valid_q is control, the fields are plain payload
	logic                        out_valid_q;
	logic                        was_member_q;
	logic                        dropped_q;
	logic [ist_pkg::COUNT_W-1:0] member_count_q;

	// Sequencer walks the stored entries through the shared compare.
	// Remove fills the freed slot with the last entry, since order is not visible.
	ist_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req_mode  (s_axis_tuser),
		.req_value (s_axis_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.count     (count),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	ist_ram #(
		.WIDTH (ist_pkg::VALUE_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Take a new result whenever the register is empty or being drained
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the fields while a result waits; count wraps to 5 bits above 31
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			was_member_q   <= res.was_member;
			dropped_q      <= res.dropped;
			member_count_q <= ist_pkg::COUNT_W'(count);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, dropped_q, member_count_q, was_member_q};

endmodule
`default_nettype wire
